FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define BPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// condition that must never be seen outside reset
`define BPC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bpc assertion failed");

`endif

FILE: src/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int BTN_W       = 2;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CNT_W       = $clog2(NUM_BUTTONS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_AFTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD  = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESSED = 2'd0,
    KIND_LONG    = 2'd1,
    KIND_RESET   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CMD_PRESS   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_START   = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] repeat_after;
    logic [CFG_W-1:0] reset_hold;
    logic [CFG_W-1:0] slow_period;
    logic [CFG_W-1:0] fast_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    long_press:   16'd3000,
    repeat_after: 16'd1000,
    reset_hold:   16'd3000,
    slow_period:  16'd500,
    fast_period:  16'd250
  };

  typedef struct packed {
    kind_e            kind;
    logic [BTN_W-1:0] which;
    logic             last;
  } res_t;

  typedef struct packed {
    logic idle;
    logic timer_running;
  } eng_status_t;

endpackage

`default_nettype wire

FILE: src/bpc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [BTN_W-1:0]  button;
  logic              level;
  logic [TIME_W-1:0] now;
  modport source (output valid, op, button, level, now, input ready);
  modport sink (input valid, op, button, level, now, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BTN_W-1:0]  which_button;
  logic              last;
  modport source (output valid, kind, which_button, last, input ready);
  modport sink (input valid, kind, which_button, last, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/bpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/bpc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bpc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bpc_pkg::cmd_t head_o
);
  import bpc_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/bpc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpc_in_if.sink        in_i,
  bpc_cfg_if.sink       cfg_i,
  output bpc_pkg::cfg_t cfg_o,
  output bpc_pkg::cmd_t cmd_o,
  output logic          push_o,
  input  logic          full_i
);
  import bpc_pkg::*;

  cfg_t                   cfg_q, cfg_d;
  logic [NUM_BUTTONS-1:0] armed_q, armed_d;
  logic [IDX_W-1:0]       idx;
  logic                   accept;
  logic                   in_range;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  assign accept   = in_i.valid && in_i.ready;
  assign idx      = IDX_W'(in_i.button);
  assign in_range = (int'(in_i.button) < NUM_BUTTONS);

  // edge classification; armed edge lives here since only edges touch it
  always_comb begin
    armed_d   = armed_q;
    cmd_o.idx = idx;
    cmd_o.now = in_i.now;
    cmd_o.cmd = CMD_TICK;
    push_o    = accept && (in_i.op || in_range);
    if (!in_i.op) begin
      if (!in_i.level && !armed_q[idx]) begin
        cmd_o.cmd = CMD_PRESS;
        if (accept && in_range) begin
          armed_d[idx] = 1'b1;
        end
      end else if (in_i.level && armed_q[idx]) begin
        cmd_o.cmd = CMD_RELEASE;
        if (accept && in_range) begin
          armed_d[idx] = 1'b0;
        end
      end else if (!in_i.level) begin
        cmd_o.cmd = CMD_START;
      end else begin
        cmd_o.cmd = CMD_CLEAR;
      end
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_LONG_PRESS:   cfg_d.long_press   = cfg_i.data;
        REG_REPEAT_AFTER: cfg_d.repeat_after = cfg_i.data;
        REG_RESET_HOLD:   cfg_d.reset_hold   = cfg_i.data;
        REG_SLOW_PERIOD:  cfg_d.slow_period  = cfg_i.data;
        REG_FAST_PERIOD:  cfg_d.fast_period  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CFG_RESET;
      armed_q <= '0;
    end else begin
      cfg_q   <= cfg_d;
      armed_q <= armed_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/bpc_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpc_pkg::cfg_t        cfg_i,
  input  logic                 head_valid_i,
  input  bpc_pkg::cmd_t        head_i,
  output logic                 pop_o,
  bpc_out_if.source            out_o,
  output bpc_pkg::eng_status_t status_o
);
  import bpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_REL  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [NUM_BUTTONS-1:0] held_q, held_d;
  logic                   run_q, run_d;
  logic [TIME_W-1:0]      deadline_q, deadline_d;
  cmd_t                   cur_q, cur_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [NUM_BUTTONS-1:0] rep_q, rep_d;
  logic [NUM_BUTTONS-1:0] rst_q, rst_d;
  logic                   reboot_q, reboot_d;
  logic                   out_valid_q, out_valid_d;
  res_t                   res_q, res_d;
  logic                   out_load;
  logic                   slot_free;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [TIME_W-1:0]      ram_rdata;
  logic [TIME_W-1:0]      elapsed;
  logic [TIME_W-1:0]      tick_diff;
  logic [IDX_W-1:0]       ev_idx;
  logic [IDX_W-1:0]       low_idx;
  logic [NUM_BUTTONS-1:0] low_mask;

  // press times, one read port shared by release and the expiry walk
  assign ram_we = pop_o && (head_i.cmd == CMD_PRESS);

  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_raddr = head_i.idx;
    end else if (state_q == ST_SCAN) begin
      ram_raddr = cnt_q[IDX_W-1:0];
    end else begin
      ram_raddr = cur_q.idx;
    end
  end

  bpc_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_BUTTONS)
  ) u_press_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.idx),
    .wdata_i (head_i.now),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign elapsed   = cur_q.now - ram_rdata;
  assign tick_diff = head_i.now - deadline_q;
  assign ev_idx    = IDX_W'(cnt_q - 1'b1);
  assign slot_free = !out_valid_q || out_o.ready;

  // lowest pending repeat
  always_comb begin
    low_idx  = '0;
    low_mask = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (rep_q[i]) begin
        low_idx  = IDX_W'(i);
        low_mask = NUM_BUTTONS'(1) << i;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    run_d      = run_q;
    deadline_d = deadline_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    rep_d      = rep_q;
    rst_d      = rst_q;
    reboot_d   = reboot_q;
    res_d      = res_q;
    out_load   = 1'b0;
    pop_o      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          cur_d = head_i;
          case (head_i.cmd)
            CMD_PRESS, CMD_START: begin
              if (head_i.cmd == CMD_PRESS) begin
                held_d[head_i.idx] = 1'b1;
              end
              if (!run_q) begin
                run_d      = 1'b1;
                deadline_d = head_i.now + TIME_W'(cfg_i.slow_period);
              end
            end
            CMD_CLEAR: held_d[head_i.idx] = 1'b0;
            CMD_RELEASE: state_d = ST_REL;
            CMD_TICK: begin
              // expired when the wrapped distance past the deadline is below half range
              if (run_q && !tick_diff[TIME_W-1]) begin
                state_d = ST_SCAN;
                cnt_d   = '0;
                rep_d   = '0;
                rst_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REL: begin
        if (!held_q[cur_q.idx]) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_load            = 1'b1;
          res_d.kind          = (elapsed > TIME_W'(cfg_i.long_press)) ? KIND_LONG : KIND_PRESSED;
          res_d.which         = BTN_W'(cur_q.idx);
          res_d.last          = 1'b1;
          held_d[cur_q.idx]   = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // read data is registered, so it belongs to the address of the step before
        if (cnt_q != '0 && held_q[ev_idx]) begin
          rep_d[ev_idx] = elapsed > TIME_W'(cfg_i.repeat_after);
          rst_d[ev_idx] = elapsed > TIME_W'(cfg_i.reset_hold);
        end
        if (cnt_q == CNT_W'(NUM_BUTTONS)) begin
          reboot_d = &rst_d;
          if (|held_q) begin
            deadline_d = cur_q.now +
                         TIME_W'((|rep_d) ? cfg_i.fast_period : cfg_i.slow_period);
          end else begin
            run_d = 1'b0;
          end
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (|rep_q) begin
          if (slot_free) begin
            out_load    = 1'b1;
            res_d.kind  = KIND_PRESSED;
            res_d.which = BTN_W'(low_idx);
            res_d.last  = ((rep_q & ~low_mask) == '0) && !reboot_q;
            rep_d       = rep_q & ~low_mask;
          end
        end else if (reboot_q) begin
          if (slot_free) begin
            out_load    = 1'b1;
            res_d.kind  = KIND_RESET;
            res_d.which = '0;
            res_d.last  = 1'b1;
            reboot_d    = 1'b0;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      run_q       <= 1'b0;
      deadline_q  <= '0;
      cnt_q       <= '0;
      rep_q       <= '0;
      rst_q       <= '0;
      reboot_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      run_q       <= run_d;
      deadline_q  <= deadline_d;
      cnt_q       <= cnt_d;
      rep_q       <= rep_d;
      rst_q       <= rst_d;
      reboot_q    <= reboot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.which_button = res_q.which;
  assign out_o.last         = res_q.last;

  assign status_o.idle          = (state_q == ST_IDLE);
  assign status_o.timer_running = run_q;

endmodule

`default_nettype wire

FILE: src/button_press_classifier_top.sv
// Button press classifier for four push buttons. Edge beats (op 0) arm and
// classify presses and releases; tick beats (op 1) drive the auto-repeat timer.
// The front end takes a beat whenever the two-entry command queue has room, so
// input is accepted while results are still waiting on the output. The back end
// takes one queued command per cycle while idle: a press, a restart or a clear
// finishes in the idle state, a release goes on to a release state because the
// press time comes from a memory with a registered read. An expiring tick walks
// the press-time memory, one button per cycle through its single read port, and
// then emits up to NUM_BUTTONS repeats and a reset request as results. A tick
// that does not expire finishes in the idle state. Registers may be written any
// time the block is idle; the write port is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module button_press_classifier_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    in_i,
  bpc_cfg_if.sink   cfg_i,
  bpc_out_if.source out_o
);
  import bpc_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  cmd_t        head;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  eng_status_t eng_status;

  bpc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .cmd_o  (cmd),
    .push_o (push),
    .full_i (q_full)
  );

  bpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  bpc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (q_pop),
    .out_o        (out_o),
    .status_o     (eng_status)
  );

  `BPC_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_valid)
  `BPC_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_full)
  `BPC_ASSERT_IMPL(a_reset_req_last, clk_i, rst_ni, out_o.valid && (out_o.kind == KIND_RESET), out_o.last && (out_o.which_button == '0))
  `BPC_ASSERT_IMPL(a_more_pending, clk_i, rst_ni, out_o.valid && !out_o.last, !eng_status.idle)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bpc_pkg::*;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic LEVEL_LOW  = 1'b0;
  localparam logic LEVEL_HIGH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_BEATS   = 25;

  typedef struct packed {
    logic              op;
    logic [BTN_W-1:0]  button;
    logic              level;
    logic [TIME_W-1:0] now;
  } in_beat_t;

  typedef struct packed {
    in_beat_t beat;
    logic     typed;
    logic     has_res;
    res_t     res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bpc_in_if  in_if ();
  bpc_cfg_if cfg_if ();
  bpc_out_if out_if ();

  button_press_classifier_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // button model
  cfg_t              cur_cfg = CFG_RESET;
  logic              btn_held       [NUM_BUTTONS];
  logic [TIME_W-1:0] btn_down_at    [NUM_BUTTONS];
  logic              btn_armed_rise [NUM_BUTTONS];
  logic              rpt_running;
  logic [TIME_W-1:0] rpt_deadline;
  res_t              step_events [$];

  res_t        pending_events [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // typed directed rows carry their own expectation alongside the beat
  logic row_typed;
  logic row_has;
  res_t row_res;

  // stimulus side
  logic              calm;
  logic              stall_req;
  logic [TIME_W-1:0] clock_now;
  int unsigned       step_max;
  logic              btn_shadow [NUM_BUTTONS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_event(input kind_e k, input logic [BTN_W-1:0] btn);
    res_t r;
    r.kind  = k;
    r.which = btn;
    r.last  = 1'b0;
    step_events.push_back(r);
  endfunction

  function automatic void start_timer(input logic [TIME_W-1:0] t);
    if (!rpt_running) begin
      rpt_running  = 1'b1;
      rpt_deadline = t + TIME_W'(cur_cfg.slow_period);
    end
  endfunction

  function automatic void classify_beat(input in_beat_t b);
    logic [TIME_W-1:0] el;
    int unsigned       down;
    int unsigned       reboot;
    int unsigned       quick;
    res_t              r;
    step_events.delete();
    down   = 0;
    reboot = 0;
    quick  = 0;
    if (b.op == OP_EDGE) begin
      if (b.level == LEVEL_LOW && !btn_armed_rise[b.button]) begin
        btn_held[b.button]       = 1'b1;
        btn_down_at[b.button]    = b.now;
        start_timer(b.now);
        btn_armed_rise[b.button] = 1'b1;
      end else if (b.level == LEVEL_HIGH && btn_armed_rise[b.button]) begin
        if (btn_held[b.button]) begin
          el = b.now - btn_down_at[b.button];
          push_event((el > TIME_W'(cur_cfg.long_press)) ? KIND_LONG : KIND_PRESSED, b.button);
        end
        btn_held[b.button]       = 1'b0;
        btn_armed_rise[b.button] = 1'b0;
      end else if (b.level == LEVEL_LOW) begin
        start_timer(b.now);
      end else begin
        btn_held[b.button] = 1'b0;
      end
    end else begin
      // expiry when running and the wrapped distance past the deadline is below half range
      el = b.now - rpt_deadline;
      if (rpt_running && !el[TIME_W-1]) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (btn_held[i]) begin
            el = b.now - btn_down_at[i];
            down++;
            if (el > TIME_W'(cur_cfg.reset_hold)) reboot++;
            if (el > TIME_W'(cur_cfg.repeat_after)) begin
              push_event(KIND_PRESSED, BTN_W'(i));
              quick++;
            end
          end
        end
        if (reboot == NUM_BUTTONS) push_event(KIND_RESET, '0);
        if (down != 0) begin
          rpt_deadline = b.now + TIME_W'(quick != 0 ? cur_cfg.fast_period : cur_cfg.slow_period);
        end else begin
          rpt_running = 1'b0;
        end
      end
    end
    if (step_events.size() > 0) begin
      r = step_events.pop_back();
      r.last = 1'b1;
      step_events.push_back(r);
    end
  endfunction

  initial begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      btn_held[i]       = 1'b0;
      btn_down_at[i]    = '0;
      btn_armed_rise[i] = 1'b0;
      btn_shadow[i]     = 1'b0;
    end
    rpt_running  = 1'b0;
    rpt_deadline = '0;
    mismatches   = 0;
    quiet_cycles = 0;
  end

  always @(posedge clk) begin : check_beats
    in_beat_t b;
    res_t     want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result: kind %0d, which_button %0d, last %0d",
                 out_if.kind, out_if.which_button, out_if.last);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (out_if.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
            mismatches++;
          end
          if (out_if.which_button !== want.which) begin
            $error("which_button: expected %0d, got %0d", want.which, out_if.which_button);
            mismatches++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_if.last);
            mismatches++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_LONG_PRESS:   cur_cfg.long_press   = cfg_if.data;
          REG_REPEAT_AFTER: cur_cfg.repeat_after = cfg_if.data;
          REG_RESET_HOLD:   cur_cfg.reset_hold   = cfg_if.data;
          REG_SLOW_PERIOD:  cur_cfg.slow_period  = cfg_if.data;
          REG_FAST_PERIOD:  cur_cfg.fast_period  = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        b.op     = in_if.op;
        b.button = in_if.button;
        b.level  = in_if.level;
        b.now    = in_if.now;
        classify_beat(b);
        if (row_typed) begin
          if (row_has) pending_events.push_back(row_res);
        end else begin
          foreach (step_events[k]) pending_events.push_back(step_events[k]);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random ready bursts, one long hold-off on request
  initial begin : result_sink
    int unsigned span;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_if.ready <= 1'b0;
        span = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        span = $urandom_range(1, 10);
      end else begin
        out_if.ready <= 1'b1;
        span = calm ? 1 : $urandom_range(1, 10);
      end
      repeat (span) @(posedge clk);
    end
  end

  function automatic dir_row_t edge_row(input logic [BTN_W-1:0] btn, input logic lvl,
                                        input logic [TIME_W-1:0] t, input logic has_res,
                                        input kind_e k);
    dir_row_t r;
    r.beat.op     = OP_EDGE;
    r.beat.button = btn;
    r.beat.level  = lvl;
    r.beat.now    = t;
    r.typed       = 1'b1;
    r.has_res     = has_res;
    r.res.kind    = k;
    r.res.which   = btn;
    r.res.last    = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic [TIME_W-1:0] t);
    dir_row_t r;
    r             = '0;
    r.beat.op     = OP_TICK;
    r.beat.button = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
    r.beat.level  = 1'($urandom_range(0, 1));
    r.beat.now    = t;
    return r;
  endfunction

  function automatic in_beat_t next_beat();
    in_beat_t    b;
    int unsigned roll;
    int unsigned i;
    roll = $urandom_range(0, 99);
    i    = $urandom_range(0, NUM_BUTTONS - 1);
    if ($urandom_range(0, 40) == 0) clock_now = $urandom();
    else clock_now = clock_now + TIME_W'($urandom_range(0, step_max));
    b.now    = clock_now;
    b.button = BTN_W'(i);
    b.level  = 1'($urandom_range(0, 1));
    if (roll < 60) begin
      // well-formed press or release following the button's own state
      b.op          = OP_EDGE;
      b.level       = btn_shadow[i] ? LEVEL_HIGH : LEVEL_LOW;
      btn_shadow[i] = !btn_shadow[i];
    end else if (roll < 88) begin
      b.op = OP_TICK;
    end else begin
      b.op          = OP_EDGE;
      btn_shadow[i] = (b.level == LEVEL_LOW);
    end
    return b;
  endfunction

  task automatic offer(input in_beat_t b, input logic typed, input logic has_res,
                       input res_t r);
    in_if.valid  <= 1'b1;
    in_if.op     <= b.op;
    in_if.button <= b.button;
    in_if.level  <= b.level;
    in_if.now    <= b.now;
    row_typed    <= typed;
    row_has      <= has_res;
    row_res      <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // a beat with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c, input logic poke_unused);
    logic [CFG_IDX_W-1:0] idx [$];
    logic [CFG_W-1:0]     val [$];
    idx = '{REG_LONG_PRESS, REG_REPEAT_AFTER, REG_RESET_HOLD, REG_SLOW_PERIOD,
            REG_FAST_PERIOD};
    val = '{c.long_press, c.repeat_after, c.reset_hold, c.slow_period, c.fast_period};
    if (poke_unused) begin
      idx.push_back(REG_NONE);
      val.push_back(CFG_W'($urandom()));
    end
    foreach (idx[k]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t plan [$];
    cfg_t     cfg;
    in_beat_t b;
    in_if.valid  = 1'b0;
    in_if.op     = OP_EDGE;
    in_if.button = '0;
    in_if.level  = LEVEL_HIGH;
    in_if.now    = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    row_typed    = 1'b0;
    row_has      = 1'b0;
    row_res      = '0;
    calm         = 1'b0;
    stall_req    = 1'b0;
    clock_now    = '0;
    step_max     = 0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; ticks are left to the model, edges are typed in
    plan = '{
      tick_row(32'hFFFF_FFFF),
      edge_row(2'd2, LEVEL_HIGH, 32'd5,         1'b0, KIND_PRESSED),
      edge_row(2'd0, LEVEL_LOW,  32'd100,       1'b0, KIND_PRESSED),
      edge_row(2'd0, LEVEL_LOW,  32'd150,       1'b0, KIND_PRESSED),
      tick_row(32'd599),
      tick_row(32'd600),
      edge_row(2'd0, LEVEL_HIGH, 32'd3100,      1'b1, KIND_PRESSED),
      edge_row(2'd1, LEVEL_LOW,  32'hFFFF_FFF0, 1'b0, KIND_PRESSED),
      edge_row(2'd1, LEVEL_HIGH, 32'h0000_0010, 1'b1, KIND_PRESSED),
      edge_row(2'd3, LEVEL_LOW,  32'd0,         1'b0, KIND_PRESSED),
      edge_row(2'd3, LEVEL_HIGH, 32'd3001,      1'b1, KIND_LONG),
      edge_row(2'd3, LEVEL_HIGH, 32'd3002,      1'b0, KIND_PRESSED),
      edge_row(2'd0, LEVEL_LOW,  32'd10000,     1'b0, KIND_PRESSED),
      edge_row(2'd1, LEVEL_LOW,  32'd10000,     1'b0, KIND_PRESSED),
      edge_row(2'd2, LEVEL_LOW,  32'd10000,     1'b0, KIND_PRESSED),
      edge_row(2'd3, LEVEL_LOW,  32'd10000,     1'b0, KIND_PRESSED),
      tick_row(32'd10000),
      tick_row(32'd14000),
      tick_row(32'd14100),
      edge_row(2'd2, LEVEL_HIGH, 32'd14200,     1'b1, KIND_LONG),
      tick_row(32'd14250),
      edge_row(2'd0, LEVEL_HIGH, 32'd20000,     1'b1, KIND_LONG),
      edge_row(2'd1, LEVEL_HIGH, 32'd20000,     1'b1, KIND_LONG),
      edge_row(2'd3, LEVEL_HIGH, 32'd20000,     1'b1, KIND_LONG),
      tick_row(32'd20000)
    };
    foreach (plan[k]) begin
      offer(plan[k].beat, plan[k].typed, plan[k].has_res, plan[k].res);
      maybe_gap();
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int i = 0; i < NUM_BUTTONS; i++) btn_shadow[i] = btn_held[i];
      case (ph)
        0: begin
          cfg = '{long_press: 16'd0, repeat_after: 16'd1, reset_hold: 16'd1,
                  slow_period: 16'd1, fast_period: 16'd1};
          step_max  = 4;
          clock_now = $urandom();
        end
        1: begin
          cfg       = '{default: 16'hFFFF};
          step_max  = 40000;
          clock_now = 32'hFFFF_0000;
        end
        2: begin
          // fast period of zero: deadline lands on the tick itself
          cfg.long_press   = CFG_W'($urandom_range(0, 300));
          cfg.repeat_after = CFG_W'($urandom_range(1, 300));
          cfg.reset_hold   = CFG_W'($urandom_range(1, 300));
          cfg.slow_period  = CFG_W'($urandom_range(1, 300));
          cfg.fast_period  = '0;
          step_max         = 400;
        end
        default: begin
          cfg.long_press   = CFG_W'($urandom_range(0, 2000));
          cfg.repeat_after = CFG_W'($urandom_range(1, 2000));
          cfg.reset_hold   = CFG_W'($urandom_range(1, 2000));
          cfg.slow_period  = CFG_W'($urandom_range(1, 2000));
          cfg.fast_period  = CFG_W'($urandom_range(1, 2000));
          step_max         = 2500;
        end
      endcase
      program_regs(cfg, ph == 0);
      if (ph == 3) calm = 1'b1;
      // hold the result side off while beats keep coming so the block backs up
      if (ph == 2) stall_req = 1'b1;
      repeat (PHASE_BEATS) begin
        b = next_beat();
        offer(b, 1'b0, 1'b0, '0);
        maybe_gap();
      end
    end

    drain();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: button_press_classifier_top.f
+incdir+src
src/bpc_pkg.sv
src/bpc_if.sv
src/bpc_ram.sv
src/bpc_fifo.sv
src/bpc_front.sv
src/bpc_engine.sv
src/button_press_classifier_top.sv
tb/tb_top.sv
